@@ design/stack_machine_executor_defines.svh @@
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

`ifndef SYNTHESIS

// checked outside reset only
`define SME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SME_ASSERT(lbl, prop, msg)
`define SME_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ design/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, word formats and fixed widths shared by the design files.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int DATA_W     = 32;
  localparam int PC_W       = 10;
  localparam int CODE_DEPTH = 1 << PC_W;
  localparam int FB_W       = 6;
  localparam logic [FB_W-1:0] FB_RESET = 6'd7;

  typedef enum logic [3:0] {
    OP_START    = 4'd0,
    OP_HALT     = 4'd1,
    OP_STORE    = 4'd2,
    OP_SCAN     = 4'd3,
    OP_PRINT    = 4'd4,
    OP_LDVAR    = 4'd5,
    OP_LDINT    = 4'd6,
    OP_ADD      = 4'd7,
    OP_SUB      = 4'd8,
    OP_GT       = 4'd9,
    OP_GTE      = 4'd10,
    OP_LT       = 4'd11,
    OP_LTE      = 4'd12,
    OP_JMPFALSE = 4'd13,
    OP_GOTO     = 4'd14
  } op_e;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] arg;
    logic signed [DATA_W-1:0] scan_value;
  } in_word_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     halted;
    logic                     fault;
  } out_word_t;

endpackage

@@ design/stack_machine_executor.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one stack machine instruction per input word, one result word each.
//
//   channel | direction | handshake              | word
//   cfg     | in        | cfg_valid_i/cfg_ready_o | frame base (6 bits)
//   in      | in        | in_valid_i/in_ready_o   | in_word_t
//   out     | out       | out_valid_o/out_ready_i | out_word_t
//
// One instruction per cycle sustained while the output is not stalled; the result
// is registered behind the execute stage. The accept cycle reads the stack memory,
// the execute stage then computes and writes back; a write-first bypass in the
// memory covers back-to-back dependent words. After reset a clearing pass zeroes
// the memory with in_ready_o low. cfg_ready_o is always high.
// A stalled output holds the execute stage; input is taken while it is free.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_defines.svh"

module stack_machine_executor
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [FB_W-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_data_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int VW = DATA_W + 2;

  // state
  logic [FB_W-1:0] fb_q;
  logic [TW-1:0]   top_q, top_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            halt_q, halt_d;
  logic            clr_q;
  logic [AW-1:0]   clr_cnt_q;

  // execute stage
  logic              s1_v_q;
  op_e               s1_op_q;
  logic [DATA_W-1:0] s1_arg_q;
  logic [DATA_W-1:0] s1_scan_q;
  logic [AW-1:0]     s1_var_q;
  logic              s1_var_ok_q;

  out_word_t out_q, out_d;
  logic      out_v_q;

  logic in_fire, s1_fire, out_go;

  // issue side
  op_e           in_op;
  logic [VW-1:0] var_sum;
  logic          var_ok;
  logic [AW-1:0] iss_tm1, iss_tm2, raddr_a;

  // memory
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] rd_a, rd_b;

  // execute logic
  logic              t_ge1, t_ge2, t_lt_d, taken, x_fault, x_pvalid;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data, a_val, b_val, alu_r, x_pval;
  logic [TW-1:0]     top_pop, top_push, top_nx;
  logic signed [DATA_W-1:0] sa, sb;

  assign out_go     = !out_v_q || out_ready_i;
  assign s1_fire    = s1_v_q && out_go;
  assign in_ready_o = !clr_q && (!s1_v_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // ---- issue: read addresses from the top the previous word leaves ----
  assign in_op   = op_e'(in_data_i.op);
  assign var_sum = {{2{in_data_i.arg[DATA_W-1]}}, in_data_i.arg}
                 + {{(VW-FB_W){1'b0}}, fb_q};
  assign var_ok  = !var_sum[VW-1] && (var_sum < VW'(STACK_DEPTH));
  assign iss_tm1 = AW'(top_d - TW'(1));
  assign iss_tm2 = AW'(top_d - TW'(2));

  always_comb begin
    case (in_op)
      OP_ADD, OP_SUB, OP_GT, OP_GTE, OP_LT, OP_LTE: raddr_a = iss_tm2;
      OP_STORE, OP_JMPFALSE:                        raddr_a = iss_tm1;
      default:                                      raddr_a = var_sum[AW-1:0];
    endcase
  end

  // ---- execute ----
  assign t_ge1    = top_q != '0;
  assign t_ge2    = top_q >= TW'(2);
  assign t_lt_d   = top_q < TW'(STACK_DEPTH);
  assign top_pop  = t_ge1 ? top_q - TW'(1) : top_q;
  assign top_push = t_lt_d ? top_q + TW'(1) : top_q;
  assign b_val    = t_ge1 ? rd_b : '0;
  assign sa       = $signed(a_val);
  assign sb       = $signed(b_val);

  always_comb begin
    case (s1_op_q)
      OP_ADD, OP_SUB, OP_GT, OP_GTE, OP_LT, OP_LTE: a_val = t_ge2 ? rd_a : '0;
      OP_STORE, OP_JMPFALSE:                        a_val = t_ge1 ? rd_a : '0;
      default:                                      a_val = s1_var_ok_q ? rd_a : '0;
    endcase
  end

  always_comb begin
    case (s1_op_q)
      OP_ADD:  alu_r = a_val + b_val;
      OP_SUB:  alu_r = a_val - b_val;
      OP_GT:   alu_r = DATA_W'(sa > sb);
      OP_GTE:  alu_r = DATA_W'(sa >= sb);
      OP_LT:   alu_r = DATA_W'(sa < sb);
      OP_LTE:  alu_r = DATA_W'(sa <= sb);
      default: alu_r = '0;
    endcase
  end

  always_comb begin
    top_nx   = top_q;
    halt_d   = halt_q;
    wr_en    = 1'b0;
    wr_addr  = s1_var_q;
    wr_data  = a_val;
    x_pvalid = 1'b0;
    x_pval   = '0;
    x_fault  = 1'b0;
    taken    = 1'b0;
    if (!halt_q) begin
      case (s1_op_q)
        OP_HALT: begin
          halt_d = 1'b1;
        end
        OP_STORE: begin
          wr_en   = s1_var_ok_q;
          x_fault = !t_ge1 || !s1_var_ok_q;
          top_nx  = top_pop;
        end
        OP_SCAN: begin
          wr_en   = s1_var_ok_q;
          wr_data = s1_scan_q;
          x_fault = !s1_var_ok_q;
        end
        OP_PRINT: begin
          x_pvalid = 1'b1;
          x_pval   = a_val;
          x_fault  = !s1_var_ok_q;
          top_nx   = top_pop;
        end
        OP_LDVAR: begin
          wr_en   = t_lt_d;
          wr_addr = top_q[AW-1:0];
          x_fault = !s1_var_ok_q || !t_lt_d;
          top_nx  = top_push;
        end
        OP_LDINT: begin
          wr_en   = t_lt_d;
          wr_addr = top_q[AW-1:0];
          wr_data = s1_arg_q;
          x_fault = !t_lt_d;
          top_nx  = top_push;
        end
        OP_ADD, OP_SUB, OP_GT, OP_GTE, OP_LT, OP_LTE: begin
          wr_en   = t_ge2;
          wr_addr = AW'(top_q - TW'(2));
          wr_data = alu_r;
          x_fault = !t_ge2;
          top_nx  = top_pop;
        end
        OP_JMPFALSE: begin
          x_fault = !t_ge1;
          taken   = a_val == '0;
          top_nx  = top_pop;
        end
        OP_GOTO: begin
          taken = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (halt_q) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = s1_arg_q[PC_W-1:0];
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  assign top_d = s1_fire ? top_nx : top_q;

  always_comb begin
    out_d.next_pc     = pc_d;
    out_d.print_valid = x_pvalid;
    out_d.print_value = x_pval;
    out_d.halted      = halt_d;
    out_d.fault       = x_fault;
  end

  // ---- memory, with the clearing pass on the write port ----
  assign ram_we    = clr_q || (s1_fire && wr_en);
  assign ram_waddr = clr_q ? clr_cnt_q : wr_addr;
  assign ram_wdata = clr_q ? '0 : wr_data;

  sme_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (in_fire),
    .raddr_a_i (raddr_a),
    .raddr_b_i (iss_tm1),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q      <= FB_RESET;
      top_q     <= '0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        fb_q <= cfg_data_i;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(STACK_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (s1_fire) begin
        top_q  <= top_nx;
        pc_q   <= pc_d;
        halt_q <= halt_d;
      end
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= in_op;
      s1_arg_q    <= in_data_i.arg;
      s1_scan_q   <= in_data_i.scan_value;
      s1_var_q    <= var_sum[AW-1:0];
      s1_var_ok_q <= var_ok;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---- assertions ----
  `SME_ASSERT_ALWAYS(a_top_bound, !rst_ni || top_q <= TW'(STACK_DEPTH), "stack top beyond depth")
  `SME_ASSERT(a_halt_sticky, halt_q |=> halt_q, "halt flag cleared outside reset")
  `SME_ASSERT(a_halt_pc, halt_q |=> $stable(pc_q), "pc moved while halted")
  `SME_ASSERT(a_clr_no_exec, clr_q |-> !s1_v_q && !out_v_q, "exec during clear")

endmodule

@@ design/sme_stack_ram.sv @@
// ----------------------------------------------------------------------------
// Stack machine data memory
// One write port, two registered read ports, write-first bypass on a match.
// ----------------------------------------------------------------------------
module sme_stack_ram
  import sme_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
